FILE: rtl/core/rbs_pkg.sv
// Shared types and constants for the ray and box slab test.
package rbs_pkg;

	localparam int THR_W = 16;
	localparam logic [THR_W-1:0] THR_RESET = 16'd1;

	// Parallel-axis information carried beside each axis's quotients
	typedef struct packed {
		logic par;
		logic in_slab;
	} rbs_axis_flags_t;

endpackage

FILE: rtl/core/rbs_div.sv
// Pipelined restoring divider, unsigned magnitudes, one quotient bit per stage.
module rbs_div #(
	parameter int NW = 49,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [NW-1:0] quo
);

	logic [DW-1:0] rem_s [0:NW];
	logic [NW-1:0] num_s [0:NW];
	logic [DW-1:0] den_s [0:NW];
	logic [NW-1:0] quo_s [0:NW];

	assign rem_s[0] = '0;
	assign num_s[0] = num;
	assign den_s[0] = den;
	assign quo_s[0] = '0;

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [DW:0] trial;
		logic        take;

		always_comb begin
			trial = {rem_s[k], num_s[k][NW-1]};
			take  = (trial >= {1'b0, den_s[k]});
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= take ? DW'(trial - {1'b0, den_s[k]}) : trial[DW-1:0];
				num_s[k+1] <= {num_s[k][NW-2:0], 1'b0};
				den_s[k+1] <= den_s[k];
				quo_s[k+1] <= {quo_s[k][NW-2:0], take};
			end
		end
	end

	assign quo = quo_s[NW];

endmodule

FILE: rtl/core/rbs_axis.sv
// One axis: slab numerators, two pipelined divisions, saturation and ordering.
module rbs_axis
	import rbs_pkg::*;
#(
	parameter int CW = 32,
	parameter int FB = 16
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [THR_W-1:0]       thr,
	input  logic signed [CW-1:0]   org,
	input  logic signed [CW-1:0]   dir,
	input  logic signed [CW-1:0]   lo,
	input  logic signed [CW-1:0]   hi,
	output logic signed [CW-1:0]   t_near,
	output logic signed [CW-1:0]   t_far,
	output rbs_axis_flags_t        flags
);

	localparam int NW = CW + 1 + FB;
	localparam logic [NW-1:0] QMAX = NW'({1'b0, {(CW-1){1'b1}}});
	localparam logic [NW-1:0] QNEG = QMAX + NW'(1);

	logic signed [CW:0] dlo, dhi;
	logic [CW:0]        alo, ahi;
	logic [CW-1:0]      dmag;

	logic [NW-1:0]      nlo_s1, nhi_s1;
	logic [CW-1:0]      dmag_s1;
	logic               neglo_s1, neghi_s1;
	rbs_axis_flags_t    flags_s1;

	always_comb begin
		dlo  = {lo[CW-1], lo} - {org[CW-1], org};
		dhi  = {hi[CW-1], hi} - {org[CW-1], org};
		alo  = dlo[CW] ? (CW+1)'(-dlo) : dlo;
		ahi  = dhi[CW] ? (CW+1)'(-dhi) : dhi;
		dmag = dir[CW-1] ? CW'(-dir) : dir;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nlo_s1           <= {alo, {FB{1'b0}}};
			nhi_s1           <= {ahi, {FB{1'b0}}};
			dmag_s1          <= dmag;
			neglo_s1         <= dlo[CW] ^ dir[CW-1];
			neghi_s1         <= dhi[CW] ^ dir[CW-1];
			flags_s1.par     <= (dmag == '0) || (dmag < CW'(thr));
			flags_s1.in_slab <= (org >= lo) && (org <= hi);
		end
	end

	logic [NW-1:0] qlo, qhi;

	rbs_div #(.NW(NW), .DW(CW)) u_div_lo (
		.clk (clk), .en (en), .num (nlo_s1), .den (dmag_s1), .quo (qlo)
	);
	rbs_div #(.NW(NW), .DW(CW)) u_div_hi (
		.clk (clk), .en (en), .num (nhi_s1), .den (dmag_s1), .quo (qhi)
	);

	// Carry signs and flags alongside the divider stages
	logic            neglo_d [0:NW];
	logic            neghi_d [0:NW];
	rbs_axis_flags_t flags_d [0:NW];

	assign neglo_d[0] = neglo_s1;
	assign neghi_d[0] = neghi_s1;
	assign flags_d[0] = flags_s1;

	for (genvar k = 0; k < NW; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (en) begin
				neglo_d[k+1] <= neglo_d[k];
				neghi_d[k+1] <= neghi_d[k];
				flags_d[k+1] <= flags_d[k];
			end
		end
	end

	function automatic logic signed [CW-1:0] sat(input logic [NW-1:0] q, input logic neg);
		logic signed [CW-1:0] r;
		if (neg) begin
			r = (q > QNEG) ? {1'b1, {(CW-1){1'b0}}} : CW'(-q[CW-1:0]);
		end else begin
			r = (q > QMAX) ? {1'b0, {(CW-1){1'b1}}} : q[CW-1:0];
		end
		return r;
	endfunction

	logic signed [CW-1:0] a, b;

	always_comb begin
		a = sat(qlo, neglo_d[NW]);
		b = sat(qhi, neghi_d[NW]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_near <= (a > b) ? b : a;
			t_far  <= (a > b) ? a : b;
			flags  <= flags_d[NW];
		end
	end

endmodule

FILE: rtl/core/ray_box_slab_intersection_core.sv
// Top level of the ray and axis-aligned box slab test.
//
// channel | dir | handshake              | payload
// s       | in  | s_tvalid / s_tready    | s_tdata: ray origin, direction, box corners
// m       | out | m_tvalid / m_tready    | m_tuser: hit; m_tdata: entry, exit distance
// cfg     | in  | cfg_valid / cfg_ready  | cfg_data: parallel threshold
//
// One item per cycle while the output stage is empty or being taken; the pipeline is
// built around the bit-per-stage restoring dividers (six of them, two per axis).
// arst_n clears the valid bits and sets the threshold to 1.
// The whole pipeline advances while the output stage is empty or being taken.
module ray_box_slab_intersection_core
	import rbs_pkg::*;
#(
	parameter int COORD_WIDTH   = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// origin_x,y,z, dir_x,y,z, box_min_x,y,z, box_max_x,y,z
	input  logic [((12*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// enter_distance, exit_distance
	output logic [((2*COORD_WIDTH-1+7)/8)*8-1:0] m_tdata,
	// hit
	output logic m_tuser,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [THR_W-1:0] cfg_data
);

	localparam int CW  = COORD_WIDTH;
	localparam int OW  = ((2*COORD_WIDTH-1+7)/8)*8;
	localparam int LAT = CW + 1 + FRACTION_BITS + 4;

	logic [THR_W-1:0] thr_q;
	logic             en;
	logic [LAT-1:0]   vld_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	assign en       = m_tready || !vld_q[LAT-1];
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	logic signed [CW-1:0] tn [0:2];
	logic signed [CW-1:0] tf [0:2];
	rbs_axis_flags_t      fl [0:2];

	for (genvar i = 0; i < 3; i++) begin : g_axis
		rbs_axis #(.CW(CW), .FB(FRACTION_BITS)) u_axis (
			.clk    (clk),
			.en     (en),
			.thr    (thr_q),
			.org    (s_tdata[i*CW +: CW]),
			.dir    (s_tdata[(3+i)*CW +: CW]),
			.lo     (s_tdata[(6+i)*CW +: CW]),
			.hi     (s_tdata[(9+i)*CW +: CW]),
			.t_near (tn[i]),
			.t_far  (tf[i]),
			.flags  (fl[i])
		);
	end

	// Fold non-parallel axes: entry is largest near distance, exit the smallest far one
	logic signed [CW-1:0] e, x;
	logic                 pass;

	always_comb begin
		e    = '0;
		x    = {1'b0, {(CW-1){1'b1}}};
		pass = 1'b1;
		for (int i = 0; i < 3; i++) begin
			if (fl[i].par) begin
				pass = pass && fl[i].in_slab;
			end else begin
				if (tn[i] > e) e = tn[i];
				if (tf[i] < x) x = tf[i];
			end
		end
	end

	logic signed [CW-1:0] e_s1, x_s1;
	logic                 pass_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			e_s1    <= e;
			x_s1    <= x;
			pass_s1 <= pass;
		end
	end

	logic hit;
	assign hit = pass_s1 && (e_s1 <= x_s1) && !x_s1[CW-1];

	always_ff @(posedge clk) begin
		if (en) begin
			m_tuser <= hit;
			m_tdata <= hit ? OW'({x_s1, e_s1[CW-2:0]}) : '0;
		end
	end

endmodule

FILE: bench/ray_box_slab_intersection_core_tb.sv
// Self-checking bench for the ray and box slab test: random and corner rays against a scoreboard.
`timescale 1ns / 1ps

module ray_box_slab_intersection_core_tb
	import rbs_pkg::*;
();

	localparam int CW = 32;
	localparam int FB = 16;
	localparam int LAT = CW + FB + 5;
	localparam int IN_W = ((12*CW+7)/8)*8;
	localparam int OUT_W = ((2*CW-1+7)/8)*8;
	localparam int IDLE_LIMIT = 20000;
	localparam logic signed [63:0] CMAX = 64'sd2147483647;
	localparam logic signed [63:0] CMIN = -64'sd2147483648;

	typedef struct {
		logic hit;
		logic [30:0] enter;
		logic [31:0] exitd;
	} slab_result_t;

	// Scoreboard: predicts the slab result of each accepted ray and checks outputs
	class slab_scoreboard;
		logic [THR_W-1:0] threshold;
		slab_result_t pending[$];
		int errors;

		function new();
			threshold = THR_RESET;
			errors = 0;
		endfunction

		function logic signed [63:0] slab_t(logic signed [63:0] bound, logic signed [63:0] o,
			logic signed [63:0] d);
			logic signed [63:0] q;
			q = ((bound - o) * 64'sd65536) / d;
			if (q > CMAX) q = CMAX;
			if (q < CMIN) q = CMIN;
			return q;
		endfunction

		function void note_ray(logic [IN_W-1:0] ray);
			logic signed [63:0] o, d, lo, hi, a, b, t, mag, enter, exitd;
			logic pass;
			slab_result_t r;
			enter = 0;
			exitd = CMAX;
			pass = 1;
			for (int ax = 0; ax < 3 && pass; ax++) begin
				o = $signed(ray[ax*CW +: CW]);
				d = $signed(ray[(3+ax)*CW +: CW]);
				lo = $signed(ray[(6+ax)*CW +: CW]);
				hi = $signed(ray[(9+ax)*CW +: CW]);
				mag = d < 0 ? -d : d;
				if (d == 0 || mag < $signed({48'd0, threshold})) begin
					pass = o >= lo && o <= hi;
				end else begin
					a = slab_t(lo, o, d);
					b = slab_t(hi, o, d);
					if (a > b) begin
						t = a; a = b; b = t;
					end
					if (a > enter) enter = a;
					if (b < exitd) exitd = b;
					pass = enter <= exitd;
				end
			end
			if (pass && exitd < 0) pass = 0;
			r.hit = pass;
			r.enter = pass ? enter[30:0] : '0;
			r.exitd = pass ? exitd[31:0] : '0;
			pending = {pending, r};
		endfunction

		function void check_result(logic hit, logic [OUT_W-1:0] data);
			slab_result_t e;
			if (pending.size() == 0) begin
				$error("unexpected result hit=%0b data=%h", hit, data);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (hit !== e.hit) begin
				$error("hit: expected %0b actual %0b", e.hit, hit);
				errors++;
			end
			if (data[30:0] !== e.enter) begin
				$error("enter_distance: expected %h actual %h", e.enter, data[30:0]);
				errors++;
			end
			if (data[62:31] !== e.exitd) begin
				$error("exit_distance: expected %h actual %h", e.exitd, data[62:31]);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready, m_tuser;
	logic [IN_W-1:0] s_tdata;
	logic [OUT_W-1:0] m_tdata;
	logic cfg_valid, cfg_ready;
	logic [THR_W-1:0] cfg_data;

	slab_scoreboard sb;
	int idle_cycles;
	bit stall_on;

	ray_box_slab_intersection_core #(.COORD_WIDTH(CW), .FRACTION_BITS(FB)) u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 60) return 0;
		if (p < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Receiver: random stalls unless stall_on, check each accepted result
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
			if (stall_on) m_tready <= 1'b1;
			else m_tready <= gap_len() == 0;
		end
	end

	// Watchdog: count cycles with nothing accepted
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Hold valid across back-to-back items; drop it only for a gap
	task automatic send_ray(logic [IN_W-1:0] ray);
		int g;
		g = gap_len();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= ray;
		do @(posedge clk); while (!s_tready);
		sb.note_ray(ray);
	endtask

	task automatic write_threshold(logic [THR_W-1:0] v);
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LAT + 4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.threshold = v;
	endtask

	function logic [31:0] rnd_coord();
		int p;
		p = $urandom_range(0, 9);
		case (p)
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return 32'($urandom_range(0, 3)) - 32'd1;
			3: return $urandom;
			default: return 32'($signed($urandom_range(0, 32'h00140000)) - 32'sh000A0000);
		endcase
	endfunction

	// Mostly well-formed ray: box around a point, ray mostly aimed at it
	function logic [IN_W-1:0] rnd_ray();
		logic [IN_W-1:0] r;
		logic signed [31:0] c, h, o, d;
		if ($urandom_range(0, 9) < 2) begin
			for (int i = 0; i < 12; i++) r[i*CW +: CW] = rnd_coord();
			return r;
		end
		for (int ax = 0; ax < 3; ax++) begin
			c = $signed($urandom_range(0, 32'h00100000)) - 32'sh00080000;
			h = $urandom_range(0, 32'h00040000);
			o = $signed($urandom_range(0, 32'h00200000)) - 32'sh00100000;
			case ($urandom_range(0, 5))
				0: d = 0;
				1: d = $signed($urandom_range(0, 32'h0000FFFF)) - 32'sh00008000;
				2: d = rnd_coord();
				default: d = (c - o) >>> $urandom_range(0, 6);
			endcase
			r[ax*CW +: CW] = o;
			r[(3+ax)*CW +: CW] = d;
			r[(6+ax)*CW +: CW] = ($urandom_range(0, 19) == 0) ? c + h : c - h;
			r[(9+ax)*CW +: CW] = ($urandom_range(0, 19) == 0) ? c - h : c + h;
		end
		return r;
	endfunction

	function logic [IN_W-1:0] make_ray(logic [31:0] o, logic [31:0] d, logic [31:0] lo,
		logic [31:0] hi);
		logic [IN_W-1:0] r;
		for (int ax = 0; ax < 3; ax++) begin
			r[ax*CW +: CW] = o;
			r[(3+ax)*CW +: CW] = d;
			r[(6+ax)*CW +: CW] = lo;
			r[(9+ax)*CW +: CW] = hi;
		end
		return r;
	endfunction

	initial begin
		logic [IN_W-1:0] r;
		sb = new();
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		m_tready = 0;
		cfg_valid = 0;
		cfg_data = '0;
		stall_on = 0;
		idle_cycles = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: hits, misses, parallel, zero direction, inverted box, extremes
		send_ray(make_ray(32'hFFFB0000, 32'h00010000, 32'hFFFF0000, 32'h00010000));
		send_ray(make_ray(32'h00050000, 32'h00010000, 32'hFFFF0000, 32'h00010000));
		send_ray(make_ray(32'h0, 32'h0, 32'hFFFF0000, 32'h00010000));
		send_ray(make_ray(32'h00020000, 32'h0, 32'hFFFF0000, 32'h00010000));
		send_ray(make_ray(32'h0, 32'h00010000, 32'h00010000, 32'hFFFF0000));
		send_ray(make_ray(32'h0, 32'h0, 32'h00010000, 32'hFFFF0000));
		send_ray(make_ray(32'h80000000, 32'h00000001, 32'h7FFFFFFF, 32'h7FFFFFFF));
		send_ray(make_ray(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF));
		send_ray(make_ray(32'h80000000, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF));
		send_ray(make_ray(32'h0, 32'hFFFF0000, 32'hFFFB0000, 32'hFFFD0000));
		send_ray(make_ray(32'hFFFFFFFF, 32'h7FFFFFFF, 32'h0, 32'hFFFFFFFF));
		send_ray(make_ray(32'h0, 32'h00000001, 32'h0, 32'h0));
		send_ray('1);
		send_ray('0);
		write_threshold(16'd0);
		send_ray(make_ray(32'h0, 32'h0, 32'h0, 32'h0));
		send_ray(make_ray(32'h0, 32'h00000001, 32'hFFFF0000, 32'h00010000));
		write_threshold(16'hFFFF);
		send_ray(make_ray(32'h0, 32'h0000FFFF, 32'hFFFF0000, 32'h00010000));
		send_ray(make_ray(32'h0, 32'hFFFF0001, 32'h00010000, 32'h00020000));
		send_ray(make_ray(32'h0, 32'h00010000, 32'hFFFF0000, 32'h00010000));

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: write_threshold(16'd1);
				1: write_threshold($urandom_range(2, 16'hFFFE));
				2: write_threshold(16'hFFFF);
				default: write_threshold(16'd0);
			endcase
			stall_on = ph == 2;
			for (int i = 0; i < 470; i++) begin
				r = rnd_ray();
				send_ray(r);
			end
		end

		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LAT + 10) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
